// File: sv/rdr_pkg.sv
// ----------------------------------------------------------------------------
// rdr_pkg: shared types and constants of the rst duty regulator
// fixed-point widths, register indexes, clamp codes and the q2.30 multiply
// ----------------------------------------------------------------------------
package rdr_pkg;

	localparam int VOLT_W        = 16;  // q8.8 voltages
	localparam int DUTY_W        = 16;  // q0.16 duty
	localparam int COEF_W        = 32;  // signed q2.30 coefficients
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int LIMITS_W      = 32;
	localparam int CLAMP_W       = 2;
	localparam int PROD_W        = COEF_W + VOLT_W + 1;
	localparam int ACC_W         = 64;  // 46 fractional bits
	localparam int FRAC_SHIFT    = 30;  // q0.16 duty to 46 fractional bits
	localparam int VOLT_SCALE_SH = 8;   // 38 to 46 fractional bits

	localparam int N_TGT_PAST  = 6;
	localparam int N_MEAS_PAST = 2;
	localparam int N_DUTY_PAST = 4;
	localparam int N_COEF_PAIR = 7;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMITS = 3'd7;

	// max 0.8 in the high half, min 0.2 in the low half, both truncated
	localparam logic [LIMITS_W-1:0] DUTY_LIMITS_RESET = 32'hCCCC_3333;

	localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
	localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
	localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

	typedef logic [VOLT_W-1:0] volt_t;
	typedef logic [DUTY_W-1:0] duty_t;

	typedef volt_t [N_TGT_PAST-1:0]  tgt_hist_t;
	typedef volt_t [N_MEAS_PAST-1:0] meas_hist_t;
	typedef duty_t [N_DUTY_PAST-1:0] duty_hist_t;

	// r holds r1..r4 at indexes 0..3
	typedef struct packed {
		logic [2:0][COEF_W-1:0] s;
		logic [3:0][COEF_W-1:0] r;
		logic [6:0][COEF_W-1:0] t;
		duty_t                  dmin;
		duty_t                  dmax;
	} rdr_coef_t;

	// signed q2.30 coefficient times an unsigned 16-bit sample
	function automatic logic signed [PROD_W-1:0] mul_q(input logic [COEF_W-1:0] c,
		input logic [VOLT_W-1:0] x);
		logic signed [COEF_W-1:0] cs;
		logic signed [VOLT_W:0]   xs;
		cs = $signed(c);
		xs = $signed({1'b0, x});
		return PROD_W'(cs * xs);
	endfunction

endpackage

// File: sv/rdr_cfg.sv
// ----------------------------------------------------------------------------
// rdr_cfg: configuration register file
// holds the coefficient pairs and duty limits, unpacks them for the law
// ----------------------------------------------------------------------------
module rdr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rdr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdr_pkg::CFG_DATA_W-1:0] cfg_data,
	output rdr_pkg::rdr_coef_t             coef
);
	import rdr_pkg::*;

	logic [N_COEF_PAIR-1:0][CFG_DATA_W-1:0] pair_q;
	logic [LIMITS_W-1:0]                    limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q   <= '0;
			limits_q <= DUTY_LIMITS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index) inside
				[REG_COEF_PAIR_0:REG_COEF_PAIR_6]: pair_q[cfg_index] <= cfg_data;
				REG_DUTY_LIMITS: limits_q <= cfg_data[LIMITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.s[0] = pair_q[0][31:0];
		coef.s[1] = pair_q[0][63:32];
		coef.s[2] = pair_q[1][31:0];
		coef.r[0] = pair_q[1][63:32];
		coef.r[1] = pair_q[2][31:0];
		coef.r[2] = pair_q[2][63:32];
		coef.r[3] = pair_q[3][31:0];
		coef.t[0] = pair_q[3][63:32];
		coef.t[1] = pair_q[4][31:0];
		coef.t[2] = pair_q[4][63:32];
		coef.t[3] = pair_q[5][31:0];
		coef.t[4] = pair_q[5][63:32];
		coef.t[5] = pair_q[6][31:0];
		coef.t[6] = pair_q[6][63:32];
		coef.dmin = limits_q[15:0];
		coef.dmax = limits_q[31:16];
	end

endmodule

// File: sv/rdr_law.sv
// ----------------------------------------------------------------------------
// rdr_law: rst control law for one sample
// fourteen products, one sum, then the clamp against the duty limits
// ----------------------------------------------------------------------------
module rdr_law (
	input  rdr_pkg::rdr_coef_t           coef,
	input  rdr_pkg::volt_t               meas,
	input  rdr_pkg::volt_t               tgt,
	input  rdr_pkg::tgt_hist_t           past_tgt,
	input  rdr_pkg::meas_hist_t          past_meas,
	input  rdr_pkg::duty_hist_t          past_duty,
	output rdr_pkg::duty_t               duty,
	output logic [rdr_pkg::CLAMP_W-1:0]  clamp
);
	import rdr_pkg::*;

	logic signed [ACC_W-1:0] vsum;
	logic signed [ACC_W-1:0] dsum;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] lim_max;
	logic signed [ACC_W-1:0] lim_min;

	always_comb begin
		// voltage terms at 38 fractional bits
		vsum = ACC_W'(mul_q(coef.t[0], tgt)) - ACC_W'(mul_q(coef.s[0], meas));
		for (int i = 0; i < N_TGT_PAST; i++)
			vsum = vsum + ACC_W'(mul_q(coef.t[i+1], past_tgt[i]));
		for (int i = 0; i < N_MEAS_PAST; i++)
			vsum = vsum - ACC_W'(mul_q(coef.s[i+1], past_meas[i]));

		// past duty terms, already at 46 fractional bits
		dsum = '0;
		for (int i = 0; i < N_DUTY_PAST; i++)
			dsum = dsum - ACC_W'(mul_q(coef.r[i], past_duty[i]));

		acc = (vsum <<< VOLT_SCALE_SH) + dsum;

		lim_max = '0;
		lim_max[FRAC_SHIFT +: DUTY_W] = coef.dmax;
		lim_min = '0;
		lim_min[FRAC_SHIFT +: DUTY_W] = coef.dmin;

		// max is checked first, so crossed limits still resolve
		if (acc > lim_max) begin
			duty  = coef.dmax;
			clamp = CLAMP_HIGH;
		end else if (acc < lim_min) begin
			duty  = coef.dmin;
			clamp = CLAMP_LOW;
		end else begin
			duty  = acc[FRAC_SHIFT +: DUTY_W];
			clamp = CLAMP_NONE;
		end
	end

endmodule

// File: sv/rst_duty_regulator.sv
// ----------------------------------------------------------------------------
// rst_duty_regulator: rst polynomial duty controller for a boost converter
// u = T(q)*target - S(q)*measured - R'(q)*duty, clamped to the duty limits
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carry one sample item per tick, a
//     measured voltage and a setpoint, both unsigned q8.8
//   output channel: out_valid/out_ready carry one result item per input item,
//     the clamped q0.16 duty and its clamp state (none, high, low)
//   config port: cfg_wr_en, cfg_index, cfg_data write one register per edge;
//     the user writes only while no item is in flight, not enforced here
//   path: an accepted item enters the input register, then the law feeds
//     the result register, where out_valid rises
//   throughput: one item per cycle unless out_ready stalls; duty feedback
//     runs through the duty history: each item sees the previous item's duty
//   stall: while out_ready is low the result holds, one more item can wait
//     in the input register, then in_ready drops
//   reset: histories clear to zero, coefficients to zero, limits to
//     max 0.8 / min 0.2, both stages empty
// ----------------------------------------------------------------------------
module rst_duty_regulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rdr_pkg::VOLT_W-1:0]     measured_voltage,
	input  logic [rdr_pkg::VOLT_W-1:0]     target_voltage,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rdr_pkg::DUTY_W-1:0]     duty,
	output logic [rdr_pkg::CLAMP_W-1:0]    clamp_state,
	input  logic                          cfg_wr_en,
	input  logic [rdr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rdr_pkg::*;

	rdr_coef_t            coef;

	// input register
	logic                 valid_s1;
	volt_t                meas_s1;
	volt_t                tgt_s1;

	// sample histories, newest at index 0
	tgt_hist_t            past_tgt_q;
	meas_hist_t           past_meas_q;
	duty_hist_t           past_duty_q;

	// result register
	logic                 out_valid_q;
	duty_t                duty_q;
	logic [CLAMP_W-1:0]   clamp_q;

	duty_t                law_duty;
	logic [CLAMP_W-1:0]   law_clamp;
	logic                 advance;

	rdr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	rdr_law u_law (
		.coef      (coef),
		.meas      (meas_s1),
		.tgt       (tgt_s1),
		.past_tgt  (past_tgt_q),
		.past_meas (past_meas_q),
		.past_duty (past_duty_q),
		.duty      (law_duty),
		.clamp     (law_clamp)
	);

	// the sample in the input register moves on when the result slot frees
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			meas_s1 <= measured_voltage;
			tgt_s1  <= target_voltage;
		end
	end

	// histories shift only when a sample is consumed by the law
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			past_tgt_q  <= '0;
			past_meas_q <= '0;
			past_duty_q <= '0;
		end else if (advance) begin
			past_tgt_q  <= {past_tgt_q[N_TGT_PAST-2:0], tgt_s1};
			past_meas_q <= {past_meas_q[N_MEAS_PAST-2:0], meas_s1};
			past_duty_q <= {past_duty_q[N_DUTY_PAST-2:0], law_duty};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_q  <= law_duty;
			clamp_q <= law_clamp;
		end
	end

	assign out_valid   = out_valid_q;
	assign duty        = duty_q;
	assign clamp_state = clamp_q;

endmodule
